// ----- hw/rtl/sorted_double_ended_queue_macros.svh -----
// assertion macros for the sorted double-ended queue checker
`ifndef SORTED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define SORTED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define SDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdq check failed");

// next-cycle implication, also active during reset
`define SDQ_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sdq check failed");

`endif

// ----- hw/rtl/sdq_pkg.sv -----
// shared types and constants of the sorted double-ended queue
package sdq_pkg;

   localparam int SDQ_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP_MIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP_MAX = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

   localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_SHIFT  = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic       occupied;
      logic       at_count;
      logic       at_last;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } result_type;

endpackage

// ----- hw/rtl/sdq_cell.sv -----
// one storage cell of the sorted chain: compare, insert, shift and rotate
module sdq_cell
   import sdq_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] in_val,
   input  logic signed [DATA_W-1:0] left_val,
   input  logic                     left_take,
   input  logic signed [DATA_W-1:0] right_val,
   input  logic signed [DATA_W-1:0] head_val,
   output logic signed [DATA_W-1:0] val,
   output logic                     take
);

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;

   // every occupied cell at or above the new value, and the free slot at the end
   assign take = ctl.at_count || (ctl.occupied && (val_ff >= in_val));
   assign val  = val_ff;

   always_comb begin
      case (ctl.op)
         CELL_INSERT: val_in = left_take ? left_val : (take ? in_val : val_ff);
         CELL_SHIFT:  val_in = right_val;
         CELL_ROTATE: val_in = ctl.at_last ? head_val : right_val;
         default:     val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ----- hw/rtl/sorted_double_ended_queue.sv -----
// Sorted double-ended queue: holds up to CAPACITY signed 32-bit values in ascending order in a
// chain of cells, cell 0 holding the smallest. Insert (command 0) and remove-smallest
// (command 1) need no extra state: every cell compares against the new value at once and the
// chain opens a gap or closes up in a single shift. Remove-largest (command 2) goes through
// a rotate state, in which the chain rotates its occupied cells one place per cycle until
// the largest entry reaches cell 0 and the original order is back. Removes from an empty
// store and commands 3 answer straight from the idle state. Results pass through a two-word
// output queue, so up to two results may wait for the consumer; the block takes no commands
// while both wait or while it rotates. A remove from an empty store returns status 1, an
// insert into a full store returns status 2, both with the minimum integer as value.
module sorted_double_ended_queue
   import sdq_pkg::*;
#(
   parameter int CAPACITY = SDQ_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic signed [DATA_W-1:0]   req_tdata,   // value
   input  logic [CMD_W-1:0]           req_tuser,   // command
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic signed [DATA_W-1:0]   rsp_tdata,   // result_value
   output logic [STATUS_W-1:0]        rsp_tuser    // status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [1:0] FIFO_FULL = 2'd2;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_ROTATE = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic [1:0]               fcnt_ff, fcnt_in;
   result_type               e0_ff, e0_in;
   result_type               e1_ff, e1_in;

   logic                     accept;
   logic                     pop;
   logic                     push;
   result_type               push_res;
   logic [1:0]               cell_op;
   logic                     rot_last;

   logic signed [DATA_W-1:0] cell_val  [CAPACITY];
   logic                     cell_take [CAPACITY];
   cell_ctl_type             cell_ctl  [CAPACITY];

   assign req_tready = (state_ff == S_IDLE) && (fcnt_ff != FIFO_FULL);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (fcnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = e0_ff.value;
   assign rsp_tuser  = e0_ff.status;
   assign rot_last   = ((CNT_W'(step_ff) + CNT_W'(1)) == count_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_val;
      logic                     left_take;
      logic signed [DATA_W-1:0] right_val;

      if (i == 0) begin : g_first
         assign left_val  = cell_val[0];
         assign left_take = 1'b0;
      end else begin : g_mid
         assign left_val  = cell_val[i-1];
         assign left_take = cell_take[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_val = cell_val[i];
      end else begin : g_inner
         assign right_val = cell_val[i+1];
      end

      assign cell_ctl[i] = '{op:       cell_op,
                             occupied: (count_ff > CNT_W'(i)),
                             at_count: (count_ff == CNT_W'(i)),
                             at_last:  (count_ff == CNT_W'(i + 1))};

      sdq_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .in_val    (req_tdata),
         .left_val  (left_val),
         .left_take (left_take),
         .right_val (right_val),
         .head_val  (cell_val[0]),
         .val       (cell_val[i]),
         .take      (cell_take[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      cell_op  = CELL_HOLD;
      push     = 1'b0;
      push_res = '{value: INT_MIN, status: ST_OK};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               push = 1'b1;
               case (req_tuser)
                  CMD_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        push_res.status = ST_FULL;
                     end else begin
                        cell_op        = CELL_INSERT;
                        count_in       = count_ff + CNT_W'(1);
                        push_res.value = req_tdata;
                     end
                  end
                  CMD_POP_MIN: begin
                     if (count_ff == CNT_W'(0)) begin
                        push_res.status = ST_EMPTY;
                     end else begin
                        cell_op        = CELL_SHIFT;
                        count_in       = count_ff - CNT_W'(1);
                        push_res.value = cell_val[0];
                     end
                  end
                  CMD_POP_MAX: begin
                     if (count_ff == CNT_W'(0)) begin
                        push_res.status = ST_EMPTY;
                     end else begin
                        push     = 1'b0;
                        state_in = S_ROTATE;
                        step_in  = '0;
                     end
                  end
                  default: begin
                     push_res.status = ST_OK;
                  end
               endcase
            end
         end
         S_ROTATE: begin
            cell_op = CELL_ROTATE;
            if (rot_last) begin
               push           = 1'b1;
               push_res.value = cell_val[0];
               count_in       = count_ff - CNT_W'(1);
               state_in       = S_IDLE;
               step_in        = '0;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      fcnt_in = fcnt_ff;
      e0_in   = e0_ff;
      e1_in   = e1_ff;
      case ({push, pop})
         2'b10: begin
            if (fcnt_ff == 2'd0) begin
               e0_in = push_res;
            end else begin
               e1_in = push_res;
            end
            fcnt_in = fcnt_ff + 2'd1;
         end
         2'b01: begin
            e0_in   = e1_ff;
            fcnt_in = fcnt_ff - 2'd1;
         end
         2'b11: begin
            if (fcnt_ff == 2'd1) begin
               e0_in = push_res;
            end else begin
               e0_in = e1_ff;
               e1_in = push_res;
            end
         end
         default: begin
            fcnt_in = fcnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         fcnt_ff  <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

// ----- hw/rtl/sdq_checker.sv -----
// port-level checks for the sorted double-ended queue and their binding
`include "sorted_double_ended_queue_macros.svh"

module sdq_checker
   import sdq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic signed [DATA_W-1:0] req_tdata,
   input logic [CMD_W-1:0]         req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic signed [DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]      rsp_tuser
);

   `SDQ_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_tvalid)
   `SDQ_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tuser != ST_BAD)
   `SDQ_ASSERT_NOW(a_fail_value, clock, reset,
      rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata == INT_MIN)
   `SDQ_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_tvalid && !rsp_tready,
      reset || (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
   `SDQ_ASSERT_NEXT(a_req_hold, clock, !reset && req_tvalid && !req_tready,
      reset || (req_tvalid && $stable(req_tdata) && $stable(req_tuser)))

endmodule

bind sorted_double_ended_queue sdq_checker u_sdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/tb_sorted_double_ended_queue.sv -----
// self-checking testbench of the sorted double-ended queue: directed table then random commands
module tb_sorted_double_ended_queue;
   import sdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
   localparam int RANDOM_WORDS = 1925;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 250;
   localparam int HOLD_AFTER   = 300;
   localparam int DRILL_ROWS   = 17;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic [7:0]               reps;
      logic                     pinned;
      logic signed [DATA_W-1:0] want_value;
      logic [STATUS_W-1:0]      want_status;
   } drill_row_type;

   // cmd, value, repeats, pinned, expected value, expected status
   drill_row_type drill_rows [DRILL_ROWS] = '{
      '{CMD_POP_MIN, 32'sh0,         8'd1, 1'b1, INT_MIN,        ST_EMPTY},
      '{CMD_POP_MAX, 32'sh0,         8'd1, 1'b1, INT_MIN,        ST_EMPTY},
      '{CMD_NOP,     32'sh1234_5678, 8'd1, 1'b1, INT_MIN,        ST_OK},
      '{CMD_INSERT,  32'sh7fff_ffff, 8'd1, 1'b1, 32'sh7fff_ffff, ST_OK},
      '{CMD_INSERT,  INT_MIN,        8'd1, 1'b1, INT_MIN,        ST_OK},
      '{CMD_INSERT,  32'sh0,         8'd1, 1'b1, 32'sh0,         ST_OK},
      '{CMD_INSERT,  -32'sd1,        8'd1, 1'b1, -32'sd1,        ST_OK},
      '{CMD_INSERT,  32'sd5,         8'd3, 1'b1, 32'sd5,         ST_OK},
      '{CMD_INSERT,  32'sh5555_5555, 8'd5, 1'b1, 32'sh5555_5555, ST_OK},
      '{CMD_INSERT,  32'shaaaa_aaaa, 8'd4, 1'b1, 32'shaaaa_aaaa, ST_OK},
      '{CMD_INSERT,  32'sd1,         8'd1, 1'b1, INT_MIN,        ST_FULL},
      '{CMD_NOP,     -32'sd1,        8'd1, 1'b1, INT_MIN,        ST_OK},
      '{CMD_POP_MIN, 32'sh0,         8'd1, 1'b1, INT_MIN,        ST_OK},
      '{CMD_POP_MAX, 32'sh0,         8'd1, 1'b1, 32'sh7fff_ffff, ST_OK},
      '{CMD_POP_MAX, 32'sh0,         8'd1, 1'b0, 32'sh0,         ST_OK},
      '{CMD_POP_MIN, 32'sh0,         8'd2, 1'b0, 32'sh0,         ST_OK},
      '{CMD_INSERT,  32'sd3,         8'd1, 1'b0, 32'sh0,         ST_OK}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic signed [DATA_W-1:0] req_tdata;   // value
   logic [CMD_W-1:0]         req_tuser;   // command
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic signed [DATA_W-1:0] rsp_tdata;   // result_value
   logic [STATUS_W-1:0]      rsp_tuser;   // status

   // expectation typed in the table travels beside the word
   logic                     pin_valid;
   logic signed [DATA_W-1:0] pin_value;
   logic [STATUS_W-1:0]      pin_status;

   logic signed [DATA_W-1:0] sorted_q[$];
   result_type               pending_results[$];
   int                       fail_count = 0;
   int                       accepted_count = 0;
   int                       cycle_count = 0;
   bit                       hold_done = 1'b0;

   sorted_double_ended_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic signed [DATA_W-1:0] value);
      result_type r;
      int         pos;
      r.value  = INT_MIN;
      r.status = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (sorted_q.size() >= SDQ_CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < sorted_q.size() && sorted_q[pos] < value) pos++;
               sorted_q.insert(pos, value);
               r.value = value;
            end
         end
         CMD_POP_MIN: begin
            if (sorted_q.size() == 0) r.status = ST_EMPTY;
            else r.value = sorted_q.pop_front();
         end
         CMD_POP_MAX: begin
            if (sorted_q.size() == 0) r.status = ST_EMPTY;
            else r.value = sorted_q.pop_back();
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag(input string msg);
      $error("%s", msg);
      fail_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      result_type predicted;
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = apply_command(req_tuser, req_tdata);
            if (pin_valid) begin
               predicted.value  = pin_value;
               predicted.status = pin_status;
            end
            pending_results.push_back(predicted);
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               flag($sformatf("result word with nothing expected: value %0d status %0d",
                              rsp_tdata, rsp_tuser));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.value)
                  flag($sformatf("result_value: expected %0d, got %0d", want.value, rsp_tdata));
               if (rsp_tuser !== want.status)
                  flag($sformatf("status: expected %0d, got %0d", want.status, rsp_tuser));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value,
                            input logic pinned, input logic signed [DATA_W-1:0] want_value,
                            input logic [STATUS_W-1:0] want_status);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      pin_valid  <= pinned;
      pin_value  <= want_value;
      pin_status <= want_status;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1: return $signed($urandom_range(0, 4)) - 2;
         2: begin
            case ($urandom_range(0, 3))
               0: return INT_MIN;
               1: return 32'sh7fff_ffff;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         3: begin
            if (sorted_q.size() > 0) return sorted_q[$urandom_range(0, sorted_q.size() - 1)];
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input int unsigned insert_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) return CMD_NOP;
      if (r < 3 + insert_pct * 97 / 100) return CMD_INSERT;
      return $urandom_range(0, 1) ? CMD_POP_MIN : CMD_POP_MAX;
   endfunction

   initial begin : stimulus
      int unsigned insert_choices [4];
      int unsigned insert_pct;
      int          burst_left;
      int          n;
      int          k;
      insert_choices = '{15, 50, 70, 90};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_INSERT;
      req_tdata  <= '0;
      pin_valid  <= 1'b0;
      pin_value  <= '0;
      pin_status <= ST_OK;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DRILL_ROWS; n++) begin
         for (k = 0; k < drill_rows[n].reps; k++) begin
            send_word(drill_rows[n].cmd, drill_rows[n].value, drill_rows[n].pinned,
                      drill_rows[n].want_value, drill_rows[n].want_status);
         end
      end

      insert_pct = 50;
      burst_left = 0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) insert_pct = insert_choices[$urandom_range(0, 3)];
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left--;
         send_word(pick_command(insert_pct), pick_value(), 1'b0, '0, ST_OK);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) flag("expected result words never arrived");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : consumer
      int mode;
      int span;
      int k;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            // long hold-off so the output queue fills and the input stalls
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(5, 60);
            for (k = 0; k < span; k++) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 99) < 85);
                  3: rsp_tready <= k[0];
                  default: rsp_tready <= (k % 4 == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

endmodule
